// ----- sv/tcfo_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the two-class oldest-first queue.
// No dependencies; used by tcfo_queue and the top level.
package tcfo_pkg;

   localparam int DEPTH_DEF    = 16;
   localparam int TAG_BITS_DEF = 16;
   localparam int SEQ_BITS     = 16;
   localparam int TAG_W        = 16;
   localparam int REQ_W        = 3;
   localparam int STATUS_W     = 2;

   localparam logic [REQ_W-1:0] REQ_ENQ0    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ENQ1    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DEQ_ANY = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DEQ0    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DEQ1    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic empty;
      logic full;
   } tcfo_qstat_type;

endpackage

// ----- sv/tcfo_cell.sv -----
`timescale 1ns / 1ps
// One queue cell: holds a tag and arrival stamp, takes its neighbor's entry on a pop.
// Standalone; instantiated in a row by tcfo_queue.
module tcfo_cell #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         load,
   input  logic         shift,
   input  logic [W-1:0] new_data,
   input  logic [W-1:0] next_data,
   output logic [W-1:0] data_out
);

   logic [W-1:0] data_ff;
   logic [W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (shift) begin
         data_in = next_data;
      end else if (load) begin
         data_in = new_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ----- sv/tcfo_queue.sv -----
`timescale 1ns / 1ps
// One class queue: a row of tcfo_cell with the head in cell 0 and a fill count.
// Depends on tcfo_pkg and tcfo_cell.
module tcfo_queue #(
   parameter int DEPTH = 16,
   parameter int W     = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    pop,
   input  logic [W-1:0]            push_data,
   output logic [W-1:0]            head_data,
   output tcfo_pkg::tcfo_qstat_type stat
);
   import tcfo_pkg::*;

   localparam int CntW = $clog2(DEPTH + 1);

   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic [W-1:0]    cell_data [DEPTH];

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + CntW'(1);
      end else if (pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [W-1:0] next_data;
      if (i == DEPTH - 1) begin : g_last
         assign next_data = push_data;
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end
      tcfo_cell #(.W(W)) u_cell (
         .clock    (clock),
         .load     (push && (count_ff == CntW'(i))),
         .shift    (pop),
         .new_data (push_data),
         .next_data(next_data),
         .data_out (cell_data[i])
      );
   end

   assign head_data  = cell_data[0];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CntW'(DEPTH));

endmodule

// ----- sv/two_class_fifo_oldest_first_top.sv -----
`timescale 1ns / 1ps
// Top level of the two-class queue with oldest-first dequeue.
// Depends on tcfo_pkg and tcfo_queue.
//
// Usage:
//   Requests enter on req_* (tuser = request type, tdata = item tag). Enqueue
//   requests append the tag, stamped with a shared 16-bit arrival counter, to the
//   queue of their class; dequeue requests take the head of one class, or the
//   older head of the two by a modular stamp compare.
//   Every request with a defined type gives one response on rsp_* (tdata = tag,
//   tuser = class and status); undefined types are taken and give none.
//   The response is registered and valid in the cycle after the request is taken.
//   One request is taken per cycle while req_tready is high; the head of each
//   queue is in cell 0 of its row, so the age compare and the pop need no memory read.
//   The response register frees in the cycle it is taken, so back-to-back
//   traffic runs at full rate. While rsp_tready is low and a response waits,
//   req_tready is low and the request is held.
//   Reset clears both fill counts, the arrival counter and the response valid.
module two_class_fifo_oldest_first_top #(
   parameter int DEPTH    = tcfo_pkg::DEPTH_DEF,
   parameter int TAG_BITS = tcfo_pkg::TAG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] item_tag
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] item_tag_res
   output logic [2:0]  rsp_tuser    // [0] item_class, [2:1] status
);
   import tcfo_pkg::*;

   localparam int TagW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int EntW = TagW + SEQ_BITS;

   logic                 req_fire;
   logic [REQ_W-1:0]     req_type;
   logic [TagW-1:0]      tag_in;
   logic [SEQ_BITS-1:0]  seq_ff;
   logic [SEQ_BITS-1:0]  seq_in;
   logic [EntW-1:0]      push_data;
   logic [EntW-1:0]      head0;
   logic [EntW-1:0]      head1;
   tcfo_qstat_type       stat0;
   tcfo_qstat_type       stat1;
   logic                 push0;
   logic                 push1;
   logic                 pop0;
   logic                 pop1;
   logic [SEQ_BITS-1:0]  age_diff;
   logic                 sel_cls;
   logic                 res_valid;
   logic [TAG_W-1:0]     res_tag;
   logic                 res_cls;
   logic [STATUS_W-1:0]  res_status;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [TAG_W-1:0]     rsp_tag_ff;
   logic [TAG_W-1:0]     rsp_tag_in;
   logic                 rsp_cls_ff;
   logic                 rsp_cls_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [STATUS_W-1:0]  rsp_status_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign req_type   = req_tuser;
   assign tag_in     = req_tdata[TagW-1:0];
   assign push_data  = {tag_in, seq_ff};
   assign age_diff   = head1[SEQ_BITS-1:0] - head0[SEQ_BITS-1:0];

   always_comb begin
      push0      = 1'b0;
      push1      = 1'b0;
      pop0       = 1'b0;
      pop1       = 1'b0;
      sel_cls    = 1'b0;
      res_valid  = 1'b1;
      res_tag    = '0;
      res_cls    = 1'b0;
      res_status = ST_OK;
      case (req_type)
         REQ_ENQ0: begin
            res_tag    = TAG_W'(tag_in);
            res_status = stat0.full ? ST_FULL : ST_OK;
            push0      = req_fire && !stat0.full;
         end
         REQ_ENQ1: begin
            res_tag    = TAG_W'(tag_in);
            res_cls    = 1'b1;
            res_status = stat1.full ? ST_FULL : ST_OK;
            push1      = req_fire && !stat1.full;
         end
         REQ_DEQ_ANY, REQ_DEQ0, REQ_DEQ1: begin
            if (req_type == REQ_DEQ1) begin
               sel_cls = 1'b1;
            end else if (req_type == REQ_DEQ_ANY) begin
               if (stat0.empty) begin
                  sel_cls = !stat1.empty;
               end else if (stat1.empty) begin
                  sel_cls = 1'b0;
               end else begin
                  sel_cls = age_diff[SEQ_BITS-1];
               end
            end
            res_cls = sel_cls;
            if (sel_cls) begin
               if (stat1.empty) begin
                  res_status = ST_EMPTY;
               end else begin
                  res_tag = TAG_W'(head1[EntW-1:SEQ_BITS]);
                  pop1    = req_fire;
               end
            end else begin
               if (stat0.empty) begin
                  res_status = ST_EMPTY;
               end else begin
                  res_tag = TAG_W'(head0[EntW-1:SEQ_BITS]);
                  pop0    = req_fire;
               end
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   assign seq_in = (push0 || push1) ? seq_ff + SEQ_BITS'(1) : seq_ff;

   tcfo_queue #(.DEPTH(DEPTH), .W(EntW)) u_queue0 (
      .clock    (clock),
      .reset    (reset),
      .push     (push0),
      .pop      (pop0),
      .push_data(push_data),
      .head_data(head0),
      .stat     (stat0)
   );

   tcfo_queue #(.DEPTH(DEPTH), .W(EntW)) u_queue1 (
      .clock    (clock),
      .reset    (reset),
      .push     (push1),
      .pop      (pop1),
      .push_data(push_data),
      .head_data(head1),
      .stat     (stat1)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_cls_in    = rsp_cls_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire && res_valid) begin
         rsp_valid_in  = 1'b1;
         rsp_tag_in    = res_tag;
         rsp_cls_in    = res_cls;
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seq_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tag_ff    <= rsp_tag_in;
      rsp_cls_ff    <= rsp_cls_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tag_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_cls_ff};

endmodule
